// ===== design/pimu_pkg.sv =====
// ----------------------------------------------------------------------------
// pimu_pkg
// shared types and operation codes of the packed integer multiply unit
// ----------------------------------------------------------------------------
package pimu_pkg;

  typedef enum logic [3:0] {
    OP_MULLW    = 4'd0,
    OP_MULLD    = 4'd1,
    OP_MULDQ    = 4'd2,
    OP_MULUDQ   = 4'd3,
    OP_MULHW    = 4'd4,
    OP_MULHUW   = 4'd5,
    OP_MADDWD   = 4'd6,
    OP_MADDUBSW = 4'd7,
    OP_MULHRSW  = 4'd8
  } op_e;

  localparam int unsigned WORD_LANES  = 8;
  localparam int unsigned DWORD_LANES = 4;
  localparam int unsigned BYTE_LANES  = 16;

  // raw lane products, registered between the multiply and combine stages
  typedef struct packed {
    op_e                           op;
    logic [WORD_LANES-1:0][33:0]   wp;  // 17x17 signed word products
    logic [DWORD_LANES-1:0][63:0]  dp;  // low 64 bits of 33x33 dword products
    logic [BYTE_LANES-1:0][17:0]   bp;  // 9x9 signed byte products
  } prod_t;

  localparam logic signed [18:0] SAT_MAX = 19'sh07FFF;
  localparam logic signed [18:0] SAT_MIN = -19'sh08000;
  localparam logic [33:0]        RND_BIAS = 34'h0000_4000;

endpackage

// ===== design/pimu_mul_stage.sv =====
// ----------------------------------------------------------------------------
// pimu_mul_stage
// lane operand extension and registered lane multipliers
// ----------------------------------------------------------------------------
module pimu_mul_stage
  import pimu_pkg::*;
(
  input  logic         clk,
  input  logic         en,
  input  op_e          op,
  input  logic [127:0] a,
  input  logic [127:0] b,
  output prod_t        prod_r
);

  logic                          sgn_w;
  logic                          sgn_d;
  logic [WORD_LANES-1:0][16:0]   wa;
  logic [WORD_LANES-1:0][16:0]   wb;
  logic [DWORD_LANES-1:0][32:0]  da;
  logic [DWORD_LANES-1:0][32:0]  db;
  logic [DWORD_LANES-1:0][65:0]  dfull;
  logic [BYTE_LANES-1:0][8:0]    ba;
  logic [BYTE_LANES-1:0][8:0]    bb;
  prod_t                         prod_nxt;

  // signed word lanes for everything except the unsigned high product
  assign sgn_w = (op != OP_MULHUW);
  assign sgn_d = (op == OP_MULDQ);

  always_comb begin
    for (int i = 0; i < WORD_LANES; i++) begin
      wa[i] = {sgn_w & a[16*i+15], a[16*i +: 16]};
      wb[i] = {sgn_w & b[16*i+15], b[16*i +: 16]};
    end
    for (int j = 0; j < DWORD_LANES; j++) begin
      da[j] = {sgn_d & a[32*j+31], a[32*j +: 32]};
      db[j] = {sgn_d & b[32*j+31], b[32*j +: 32]};
    end
    // unsigned a byte, signed b byte
    for (int k = 0; k < BYTE_LANES; k++) begin
      ba[k] = {1'b0, a[8*k +: 8]};
      bb[k] = {b[8*k+7], b[8*k +: 8]};
    end
  end

  always_comb begin
    prod_nxt.op = op;
    for (int i = 0; i < WORD_LANES; i++) begin
      prod_nxt.wp[i] = $signed(wa[i]) * $signed(wb[i]);
    end
    for (int j = 0; j < DWORD_LANES; j++) begin
      dfull[j]       = $signed(da[j]) * $signed(db[j]);
      prod_nxt.dp[j] = dfull[j][63:0];
    end
    for (int k = 0; k < BYTE_LANES; k++) begin
      prod_nxt.bp[k] = $signed(ba[k]) * $signed(bb[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== design/pimu_combine_stage.sv =====
// ----------------------------------------------------------------------------
// pimu_combine_stage
// pair sums, saturation, rounding and lane selection into the result register
// ----------------------------------------------------------------------------
module pimu_combine_stage
  import pimu_pkg::*;
(
  input  logic         clk,
  input  logic         en,
  input  prod_t        prod,
  output logic [127:0] result_r
);

  logic [DWORD_LANES-1:0][32:0]  dsum;
  logic [WORD_LANES-1:0][18:0]   bsum;
  logic [WORD_LANES-1:0][15:0]   bsat;
  logic [WORD_LANES-1:0][33:0]   rnd;
  logic [127:0]                  result_nxt;

  always_comb begin
    for (int j = 0; j < DWORD_LANES; j++) begin
      dsum[j] = {1'b0, prod.wp[2*j][31:0]} + {1'b0, prod.wp[2*j+1][31:0]};
    end
    for (int i = 0; i < WORD_LANES; i++) begin
      bsum[i] = {prod.bp[2*i][17], prod.bp[2*i]} + {prod.bp[2*i+1][17], prod.bp[2*i+1]};
      if ($signed(bsum[i]) > SAT_MAX) begin
        bsat[i] = 16'h7FFF;
      end else if ($signed(bsum[i]) < SAT_MIN) begin
        bsat[i] = 16'h8000;
      end else begin
        bsat[i] = bsum[i][15:0];
      end
      rnd[i] = prod.wp[i] + RND_BIAS;
    end
  end

  always_comb begin
    result_nxt = '0;
    case (prod.op)
      OP_MULLW: begin
        for (int i = 0; i < WORD_LANES; i++) result_nxt[16*i +: 16] = prod.wp[i][15:0];
      end
      OP_MULLD: begin
        for (int j = 0; j < DWORD_LANES; j++) result_nxt[32*j +: 32] = prod.dp[j][31:0];
      end
      OP_MULDQ, OP_MULUDQ: begin
        result_nxt = {prod.dp[2], prod.dp[0]};
      end
      OP_MULHW, OP_MULHUW: begin
        for (int i = 0; i < WORD_LANES; i++) result_nxt[16*i +: 16] = prod.wp[i][31:16];
      end
      OP_MADDWD: begin
        for (int j = 0; j < DWORD_LANES; j++) result_nxt[32*j +: 32] = dsum[j][31:0];
      end
      OP_MADDUBSW: begin
        for (int i = 0; i < WORD_LANES; i++) result_nxt[16*i +: 16] = bsat[i];
      end
      OP_MULHRSW: begin
        for (int i = 0; i < WORD_LANES; i++) result_nxt[16*i +: 16] = rnd[i][30:15];
      end
      default: begin
        result_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
    end
  end

endmodule

// ===== design/packed_integer_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// packed_integer_multiply_unit
// three stage packed integer multiplier for 128-bit operand slices
// ----------------------------------------------------------------------------
// usage
//   in_*  : one request per slice: operation code plus the two 128-bit
//           operands, each split into low and high 64-bit halves
//   out_* : one 128-bit result slice per request, in request order
//   both channels: a request moves on a rising edge with valid high and
//   stall low; stall is driven by the receiving side
// throughput and stages
//   one request per cycle is taken while the output side keeps stall low;
//   a request passes the stage a, b and c registers on its way to out_*:
//   stage a registers the request, stage b holds the lane multipliers,
//   stage c sums, saturates, rounds and selects into the output register
// stalls
//   each stage moves when it is empty or the stage after it moves, so
//   bubbles close up and a stalled result waits in the output register
//   while earlier stages keep filling; in_stall rises only when all three
//   stages hold a request and the output is stalled
// reset
//   rst_n low clears the stage valid bits, dropping requests in flight;
//   otherwise no request is lost or repeated; unknown operation codes give an all-zero result slice
// ----------------------------------------------------------------------------
module packed_integer_multiply_unit
  import pimu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic [63:0] in_a_low,
  input  logic [63:0] in_a_high,
  input  logic [63:0] in_b_low,
  input  logic [63:0] in_b_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_low,
  output logic [63:0] out_result_high
);

  // stage valid bits
  logic valid_a_r, valid_a_nxt;
  logic valid_b_r, valid_b_nxt;
  logic valid_c_r, valid_c_nxt;

  // stage advance enables, from the output back
  logic en_a, en_b, en_c;

  // stage a payload
  op_e          op_r;
  logic [127:0] a_r;
  logic [127:0] b_r;

  prod_t        prod_r;
  logic [127:0] result_r;

  assign en_c = !valid_c_r || !out_stall;
  assign en_b = !valid_b_r || en_c;
  assign en_a = !valid_a_r || en_b;

  assign in_stall = !en_a;

  // a stage takes whatever the stage before holds, bubbles included
  assign valid_a_nxt = en_a ? in_valid  : valid_a_r;
  assign valid_b_nxt = en_b ? valid_a_r : valid_b_r;
  assign valid_c_nxt = en_c ? valid_b_r : valid_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
    end else begin
      valid_a_r <= valid_a_nxt;
      valid_b_r <= valid_b_nxt;
      valid_c_r <= valid_c_nxt;
    end
  end

  // request register, no reset on payload
  always_ff @(posedge clk) begin
    if (en_a) begin
      op_r <= op_e'(in_action);
      a_r  <= {in_a_high, in_a_low};
      b_r  <= {in_b_high, in_b_low};
    end
  end

  // lane multipliers
  pimu_mul_stage u_mul (
    .clk    (clk),
    .en     (en_b),
    .op     (op_r),
    .a      (a_r),
    .b      (b_r),
    .prod_r (prod_r)
  );

  // combine and output register
  pimu_combine_stage u_combine (
    .clk      (clk),
    .en       (en_c),
    .prod     (prod_r),
    .result_r (result_r)
  );

  assign out_valid       = valid_c_r;
  assign out_result_low  = result_r[63:0];
  assign out_result_high = result_r[127:64];

endmodule

// ===== design/pimu_checker.sv =====
// ----------------------------------------------------------------------------
// pimu_checker
// port level checks of the packed integer multiply unit, bound to the top
// ----------------------------------------------------------------------------
module pimu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_result_low,
  input logic [63:0] out_result_high
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_low)
                               && $stable(out_result_high))
    else $error("stalled result changed");

  // input is only held off when the output holds a result and is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // a taken request reaches the output when the output side keeps up
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing three cycles after request");

endmodule

bind packed_integer_multiply_unit pimu_checker u_pimu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_low  (out_result_low),
  .out_result_high (out_result_high)
);

// ===== bench/tb_packed_integer_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// tb_packed_integer_multiply_unit
// self-checking bench for the packed integer multiply unit: a queue-fed
// driver sends directed and random operand slices, a built-in lane predictor
// works out each result slice, and a monitor checks results in request order
// while both sides idle and stall in random bursts
// ----------------------------------------------------------------------------
module tb_packed_integer_multiply_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pimu_pkg::*;

  // codes past the last defined operation, all expected to give zero
  localparam logic [3:0] OP_FIRST_UNUSED = 4'(OP_MULHRSW + 1);
  localparam logic [3:0] OP_LAST_UNUSED  = 4'hF;

  // lane arithmetic constants
  localparam int WORD_SAT_HI = 32767;
  localparam int WORD_SAT_LO = -32768;
  localparam int ROUND_BIAS  = 'h4000;

  localparam int RANDOM_REQUESTS = 850;
  localparam int TAIL_REQUESTS   = 100;  // no idling once this few are left
  localparam int DRAIN_CYCLES    = 12;   // pipeline is three deep, with margin

  typedef struct packed {
    logic [3:0]   action;
    logic [127:0] a;
    logic [127:0] b;
  } mul_request_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } mul_slice_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_action = '0;
  logic [63:0] in_a_low = '0;
  logic [63:0] in_a_high = '0;
  logic [63:0] in_b_low = '0;
  logic [63:0] in_b_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_low;
  logic [63:0] out_result_high;

  mul_request_t pending_requests[$];  // requests not yet offered to the unit
  mul_slice_t   expected_slices[$];   // predicted slices, oldest first
  int           mismatch_count = 0;
  logic         tail_phase = 1'b0;    // set near the end: no gaps, no stalls

  packed_integer_multiply_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_a_low        (in_a_low),
    .in_a_high       (in_a_high),
    .in_b_low        (in_b_low),
    .in_b_high       (in_b_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_low  (out_result_low),
    .out_result_high (out_result_high)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // lane predictor: one 128-bit result slice per request
  // ---------------------------------------------------------------------------
  function automatic mul_slice_t predict_product(logic [3:0] action, logic [127:0] a,
                                                 logic [127:0] b);
    logic [127:0]       r;
    logic signed [63:0] wide_a, wide_b;
    logic [63:0]        uns_a, uns_b, prod;
    int                 a0, b0, a1, b1, acc;
    r = '0;
    case (action)
      OP_MULLW: begin
        for (int i = 0; i < 8; i++) r[16*i +: 16] = a[16*i +: 16] * b[16*i +: 16];
      end
      OP_MULLD: begin
        for (int i = 0; i < 4; i++) r[32*i +: 32] = a[32*i +: 32] * b[32*i +: 32];
      end
      OP_MULDQ: begin
        // even dwords only, full signed 64-bit product
        for (int i = 0; i < 2; i++) begin
          wide_a = $signed(a[64*i +: 32]);
          wide_b = $signed(b[64*i +: 32]);
          r[64*i +: 64] = wide_a * wide_b;
        end
      end
      OP_MULUDQ: begin
        for (int i = 0; i < 2; i++) begin
          uns_a = a[64*i +: 32];
          uns_b = b[64*i +: 32];
          r[64*i +: 64] = uns_a * uns_b;
        end
      end
      OP_MULHW: begin
        for (int i = 0; i < 8; i++) begin
          a0 = $signed(a[16*i +: 16]);
          b0 = $signed(b[16*i +: 16]);
          acc = a0 * b0;
          r[16*i +: 16] = acc[31:16];
        end
      end
      OP_MULHUW: begin
        for (int i = 0; i < 8; i++) begin
          uns_a = a[16*i +: 16];
          uns_b = b[16*i +: 16];
          prod = uns_a * uns_b;
          r[16*i +: 16] = prod[31:16];
        end
      end
      OP_MADDWD: begin
        // two signed word products summed, wrapping at 32 bits
        for (int i = 0; i < 4; i++) begin
          a0 = $signed(a[32*i +: 16]);
          b0 = $signed(b[32*i +: 16]);
          a1 = $signed(a[32*i+16 +: 16]);
          b1 = $signed(b[32*i+16 +: 16]);
          acc = a0 * b0 + a1 * b1;
          r[32*i +: 32] = acc;
        end
      end
      OP_MADDUBSW: begin
        // unsigned byte of a times signed byte of b, pair sum clamped to a word
        for (int i = 0; i < 8; i++) begin
          a0 = a[16*i +: 8];
          b0 = $signed(b[16*i +: 8]);
          a1 = a[16*i+8 +: 8];
          b1 = $signed(b[16*i+8 +: 8]);
          acc = a0 * b0 + a1 * b1;
          if (acc > WORD_SAT_HI) acc = WORD_SAT_HI;
          else if (acc < WORD_SAT_LO) acc = WORD_SAT_LO;
          r[16*i +: 16] = acc[15:0];
        end
      end
      OP_MULHRSW: begin
        // rounded high half; the most negative squared wraps rather than clamps
        for (int i = 0; i < 8; i++) begin
          a0 = $signed(a[16*i +: 16]);
          b0 = $signed(b[16*i +: 16]);
          acc = a0 * b0 + ROUND_BIAS;
          r[16*i +: 16] = acc[30:15];
        end
      end
      default: r = '0;
    endcase
    return '{result_high: r[127:64], result_low: r[63:0]};
  endfunction

  // operand slice: fully random, or built from corner lanes of words or bytes
  function automatic logic [127:0] rand_operand();
    logic [127:0] v;
    int           mode;
    v = {$urandom, $urandom, $urandom, $urandom};
    mode = $urandom_range(0, 3);
    if (mode == 2) begin
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 5))
          0: v[16*i +: 16] = 16'h0000;
          1: v[16*i +: 16] = 16'hFFFF;
          2: v[16*i +: 16] = 16'h8000;
          3: v[16*i +: 16] = 16'h7FFF;
          4: v[16*i +: 16] = 16'h0001;
          default: ;
        endcase
      end
    end else if (mode == 3) begin
      // byte corners drive the saturating multiply-add to both rails
      for (int i = 0; i < 16; i++) begin
        case ($urandom_range(0, 4))
          0: v[8*i +: 8] = 8'h00;
          1: v[8*i +: 8] = 8'hFF;
          2: v[8*i +: 8] = 8'h80;
          3: v[8*i +: 8] = 8'h7F;
          default: ;
        endcase
      end
    end
    return v;
  endfunction

  task automatic queue_request(logic [3:0] action, logic [127:0] a, logic [127:0] b);
    pending_requests.push_back('{action: action, a: a, b: b});
  endtask

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued requests, idles in short random bursts, holds the
  // payload steady while the unit stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mul_request_t req;
    int           send_gap;
    int           send_calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      send_calm = 0;
    end else begin
      // a request moving now gets its prediction queued
      if (in_valid && !in_stall) begin
        expected_slices.push_back(predict_product(in_action, {in_a_high, in_a_low},
                                                  {in_b_high, in_b_low}));
      end
      tail_phase <= (pending_requests.size() < TAIL_REQUESTS);

      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);

      if (!(in_valid && in_stall)) begin
        if (send_gap == 0 && !tail_phase && send_calm == 0 && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 4);
        if (send_gap > 0 || pending_requests.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          req = pending_requests.pop_front();
          in_valid  <= 1'b1;
          in_action <= req.action;
          in_a_low  <= req.a[63:0];
          in_a_high <= req.a[127:64];
          in_b_low  <= req.b[63:0];
          in_b_high <= req.b[127:64];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result that moves against the oldest prediction and
  // applies back-pressure in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mul_slice_t want;
    int         hold_left;
    int         recv_calm;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      recv_calm = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_slices.size() == 0) begin
          note_mismatch($sformatf("result with no request pending: high %h low %h",
                                  out_result_high, out_result_low));
        end else begin
          want = expected_slices.pop_front();
          if (out_result_high !== want.result_high || out_result_low !== want.result_low)
            note_mismatch($sformatf("result_high exp %h got %h, result_low exp %h got %h",
                                    want.result_high, out_result_high,
                                    want.result_low, out_result_low));
        end
      end

      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(20, 60);

      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!tail_phase && recv_calm == 0 && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [3:0] code;
    // every operation on the most negative word lanes and on all-ones lanes
    for (int c = OP_MULLW; c <= OP_MULHRSW; c++) begin
      queue_request(4'(c), {8{16'h8000}}, {8{16'h8000}});
      queue_request(4'(c), '1, '1);
    end
    // saturating multiply-add at both rails
    queue_request(OP_MADDUBSW, {16{8'hFF}}, {16{8'h7F}});
    queue_request(OP_MADDUBSW, {16{8'hFF}}, {16{8'h80}});
    queue_request(OP_MULHRSW, {8{16'h7FFF}}, {8{16'h7FFF}});
    queue_request(OP_MULLD, '0, rand_operand());
    // undefined codes give an all-zero slice
    queue_request(OP_FIRST_UNUSED, rand_operand(), rand_operand());
    queue_request(OP_LAST_UNUSED, '1, '1);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 15) == 0)
        code = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      else
        code = 4'($urandom_range(OP_MULLW, OP_MULHRSW));
      queue_request(code, rand_operand(), rand_operand());
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_slices.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== packed_integer_multiply_unit.f =====
design/pimu_pkg.sv
design/pimu_mul_stage.sv
design/pimu_combine_stage.sv
design/packed_integer_multiply_unit.sv
design/pimu_checker.sv
bench/tb_packed_integer_multiply_unit.sv
